@@ rtl/mi3_pkg.sv @@
// shared types and constants for the 3x3 adjugate matrix inverse
// no dependencies
package mi3_pkg;

  localparam int DATA_W   = 32;
  localparam int ADJ_W    = 2 * DATA_W + 1;
  localparam int DET_W    = 3 * DATA_W + 3;
  localparam int THR_W    = 31;
  localparam int N_ENT    = 9;

  localparam int COF_STAGES = 2;
  localparam int DET_STAGES = 4;
  localparam int DIV_STAGES = DATA_W + 2;
  localparam int PIPE_DEPTH = COF_STAGES + DET_STAGES + DIV_STAGES;

  typedef logic signed [DATA_W-1:0]   entry_t;
  typedef logic signed [2*DATA_W-1:0] prod_t;
  typedef logic signed [ADJ_W-1:0]    adj_t;
  typedef logic [ADJ_W-1:0]           adj_mag_t;
  typedef logic signed [DET_W-1:0]    det_t;
  typedef logic [DET_W-1:0]           det_mag_t;
  typedef logic [THR_W-1:0]           thr_t;

  typedef entry_t   entry_arr_t [N_ENT];
  typedef adj_t     adj_arr_t [N_ENT];
  typedef adj_mag_t mag_arr_t [N_ENT];

  // cofactor i = m[PA_X]*m[PA_Y] - m[PB_X]*m[PB_Y]
  localparam int unsigned PA_X [N_ENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned PA_Y [N_ENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned PB_X [N_ENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned PB_Y [N_ENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  localparam entry_t SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam entry_t SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

@@ rtl/mi3_if.sv @@
// request channels for matrix in and inverse out
// depends on mi3_pkg
interface mi3_in_if import mi3_pkg::*; ();
  logic   valid;
  logic   ready;
  entry_t in_c0_r0, in_c0_r1, in_c0_r2;
  entry_t in_c1_r0, in_c1_r1, in_c1_r2;
  entry_t in_c2_r0, in_c2_r1, in_c2_r2;

  modport source (output valid, in_c0_r0, in_c0_r1, in_c0_r2, in_c1_r0, in_c1_r1,
                  in_c1_r2, in_c2_r0, in_c2_r1, in_c2_r2, input ready);
  modport sink (input valid, in_c0_r0, in_c0_r1, in_c0_r2, in_c1_r0, in_c1_r1,
                in_c1_r2, in_c2_r0, in_c2_r1, in_c2_r2, output ready);
endinterface

interface mi3_out_if import mi3_pkg::*; ();
  logic   valid;
  logic   ready;
  entry_t out_c0_r0, out_c0_r1, out_c0_r2;
  entry_t out_c1_r0, out_c1_r1, out_c1_r2;
  entry_t out_c2_r0, out_c2_r1, out_c2_r2;
  logic   singular;
  logic   saturated;

  modport source (output valid, out_c0_r0, out_c0_r1, out_c0_r2, out_c1_r0, out_c1_r1,
                  out_c1_r2, out_c2_r0, out_c2_r1, out_c2_r2, singular, saturated,
                  input ready);
  modport sink (input valid, out_c0_r0, out_c0_r1, out_c0_r2, out_c1_r0, out_c1_r1,
                out_c1_r2, out_c2_r0, out_c2_r1, out_c2_r2, singular, saturated,
                output ready);
endinterface

@@ rtl/mi3_cofactor.sv @@
// cofactor stages: eighteen 32x32 products, then nine differences
// depends on mi3_pkg
module mi3_cofactor import mi3_pkg::*; (
  input  logic                  clk,
  input  logic [COF_STAGES-1:0] en,
  input  entry_arr_t            m,
  output adj_arr_t              adj,
  output entry_t                m0,
  output entry_t                m3,
  output entry_t                m6
);

  prod_t  pa [N_ENT];
  prod_t  pb [N_ENT];
  entry_t c0, c3, c6;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < N_ENT; i++) begin
        pa[i] <= m[PA_X[i]] * m[PA_Y[i]];
        pb[i] <= m[PB_X[i]] * m[PB_Y[i]];
      end
      c0 <= m[0];
      c3 <= m[3];
      c6 <= m[6];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < N_ENT; i++) begin
        adj[i] <= ADJ_W'(pa[i]) - ADJ_W'(pb[i]);
      end
      m0 <= c0;
      m3 <= c3;
      m6 <= c6;
    end
  end

endmodule

@@ rtl/mi3_det.sv @@
// determinant stages: split products, term sums, total, magnitude and singular test
// depends on mi3_pkg
module mi3_det import mi3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic [DET_STAGES-1:0] en,
  input  thr_t                  thr,
  input  adj_arr_t              adj,
  input  entry_t                m0,
  input  entry_t                m3,
  input  entry_t                m6,
  output det_mag_t              abs_det,
  output logic                  sing,
  output mag_arr_t              mag,
  output logic [N_ENT-1:0]      neg
);

  adj_t     pl [3];
  adj_t     ph [3];
  det_t     term [3];
  det_t     det;
  mag_arr_t mag_a, mag_b, mag_c;
  logic [N_ENT-1:0] an_a, an_b, an_c;
  det_mag_t abs_c;
  det_mag_t limit;
  entry_t   mc [3];

  assign mc[0] = m0;
  assign mc[1] = m3;
  assign mc[2] = m6;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        pl[i] <= mc[i] * $signed({1'b0, adj[i][DATA_W-1:0]});
        ph[i] <= mc[i] * $signed(adj[i][ADJ_W-1:DATA_W]);
      end
      for (int i = 0; i < N_ENT; i++) begin
        mag_a[i] <= adj[i][ADJ_W-1] ? adj_mag_t'(-adj[i]) : adj_mag_t'(adj[i]);
        an_a[i]  <= adj[i][ADJ_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        term[i] <= (DET_W'(ph[i]) <<< DATA_W) + DET_W'(pl[i]);
      end
      mag_b <= mag_a;
      an_b  <= an_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      det   <= term[0] + term[1] + term[2];
      mag_c <= mag_b;
      an_c  <= an_b;
    end
  end

  always_comb begin
    abs_c = det[DET_W-1] ? det_mag_t'(-det) : det_mag_t'(det);
    limit = det_mag_t'(thr) << (2 * FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      abs_det <= abs_c;
      sing    <= abs_c <= limit;
      mag     <= mag_c;
      neg     <= an_c ^ {N_ENT{det[DET_W-1]}};
    end
  end

endmodule

@@ rtl/mi3_divider.sv @@
// one lane of the pipelined restoring divider, one quotient bit per stage,
// with overflow check up front and saturation at the end; depends on mi3_pkg
module mi3_divider import mi3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  adj_mag_t              mag,
  input  det_mag_t              den,
  input  logic                  neg,
  input  logic                  sing,
  output entry_t                q,
  output logic                  sat,
  output logic                  sing_out
);

  localparam int NW = ADJ_W + 2 * FRAC_BITS;
  localparam int DW = DET_W + DATA_W + 1;
  localparam int CW = (NW > DW) ? NW : DW;

  logic [CW-1:0]     rem   [DATA_W+1];
  logic [DATA_W-1:0] qv    [DATA_W+1];
  det_mag_t          den_s [DATA_W+1];
  logic [DATA_W:0]   neg_s, sing_s, ovf_s;
  logic [DATA_W-1:0] qf;
  logic [CW-1:0]     num;

  assign num = CW'({mag, {(2*FRAC_BITS){1'b0}}});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0]    <= num;
      qv[0]     <= '0;
      den_s[0]  <= den;
      neg_s[0]  <= neg;
      sing_s[0] <= sing;
      ovf_s[0]  <= num >= (CW'(den) << DATA_W);
    end
  end

  for (genvar j = 1; j <= DATA_W; j++) begin : g_bit
    localparam int B = DATA_W - j;
    logic [CW:0] diff;
    assign diff = {1'b0, rem[j-1]} - {1'b0, CW'(den_s[j-1]) << B};
    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem[j]    <= diff[CW] ? rem[j-1] : diff[CW-1:0];
        qv[j]     <= qv[j-1] | (diff[CW] ? '0 : (DATA_W'(1) << B));
        den_s[j]  <= den_s[j-1];
        neg_s[j]  <= neg_s[j-1];
        sing_s[j] <= sing_s[j-1];
        ovf_s[j]  <= ovf_s[j-1];
      end
    end
  end

  assign qf = qv[DATA_W];

  always_ff @(posedge clk) begin
    if (en[DATA_W+1]) begin
      sing_out <= sing_s[DATA_W];
      priority if (sing_s[DATA_W]) begin
        q   <= '0;
        sat <= 1'b0;
      end else if (!neg_s[DATA_W]) begin
        if (ovf_s[DATA_W] || qf[DATA_W-1]) begin
          q   <= SAT_POS;
          sat <= 1'b1;
        end else begin
          q   <= entry_t'(qf);
          sat <= 1'b0;
        end
      end else begin
        if (ovf_s[DATA_W] || (qf[DATA_W-1] && |qf[DATA_W-2:0])) begin
          q   <= SAT_NEG;
          sat <= 1'b1;
        end else begin
          q   <= entry_t'(-qf);
          sat <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/mat3_inverse_adjugate.sv @@
// top level: 3x3 matrix inverse by adjugate, Q16.16 in and out
// depends on mi3_pkg, mi3_if, mi3_cofactor, mi3_det, mi3_divider
//
// channel   dir  handshake      payload
// din       in   valid/ready    in_c0_r0 .. in_c2_r2
// dout      out  valid/ready    out_c0_r0 .. out_c2_r2, singular, saturated
// wr_*      in   wr_en          wr_data (singular threshold)
//
// one matrix per cycle unless dout holds off ready; pipeline of 2 cofactor, 4 determinant,
// 34 divider stages (one quotient bit per stage of the restoring divider)
// each stage advances when it is empty or the stage after it moves
// reset clears the valid bits and the threshold register

module mat3_inverse_adjugate import mi3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  mi3_in_if.sink     din,
  mi3_out_if.source  dout,
  input  logic       wr_en,
  input  thr_t       wr_data
);

  thr_t                thr;
  logic [PIPE_DEPTH-1:0] v;
  logic [PIPE_DEPTH:0]   en;
  entry_arr_t          m;
  adj_arr_t            adj;
  entry_t              m0, m3, m6;
  det_mag_t            abs_det;
  logic                sing;
  mag_arr_t            mag;
  logic [N_ENT-1:0]    neg;
  entry_t              q [N_ENT];
  logic [N_ENT-1:0]    sat, sing_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
    end else if (wr_en) begin
      thr <= wr_data;
    end
  end

  always_comb begin
    en[PIPE_DEPTH] = dout.ready;
    for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        if (en[k]) begin
          v[k] <= (k == 0) ? din.valid : v[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign din.ready = en[0];

  assign m[0] = din.in_c0_r0;
  assign m[1] = din.in_c0_r1;
  assign m[2] = din.in_c0_r2;
  assign m[3] = din.in_c1_r0;
  assign m[4] = din.in_c1_r1;
  assign m[5] = din.in_c1_r2;
  assign m[6] = din.in_c2_r0;
  assign m[7] = din.in_c2_r1;
  assign m[8] = din.in_c2_r2;

  mi3_cofactor u_cof (
    .clk (clk),
    .en  (en[COF_STAGES-1:0]),
    .m   (m),
    .adj (adj),
    .m0  (m0),
    .m3  (m3),
    .m6  (m6)
  );

  mi3_det #(.FRAC_BITS(FRAC_BITS)) u_det (
    .clk     (clk),
    .en      (en[COF_STAGES +: DET_STAGES]),
    .thr     (thr),
    .adj     (adj),
    .m0      (m0),
    .m3      (m3),
    .m6      (m6),
    .abs_det (abs_det),
    .sing    (sing),
    .mag     (mag),
    .neg     (neg)
  );

  for (genvar i = 0; i < N_ENT; i++) begin : g_lane
    mi3_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk      (clk),
      .en       (en[COF_STAGES + DET_STAGES +: DIV_STAGES]),
      .mag      (mag[i]),
      .den      (abs_det),
      .neg      (neg[i]),
      .sing     (sing),
      .q        (q[i]),
      .sat      (sat[i]),
      .sing_out (sing_o[i])
    );
  end

  assign dout.valid     = v[PIPE_DEPTH-1];
  assign dout.out_c0_r0 = q[0];
  assign dout.out_c0_r1 = q[1];
  assign dout.out_c0_r2 = q[2];
  assign dout.out_c1_r0 = q[3];
  assign dout.out_c1_r1 = q[4];
  assign dout.out_c1_r2 = q[5];
  assign dout.out_c2_r0 = q[6];
  assign dout.out_c2_r1 = q[7];
  assign dout.out_c2_r2 = q[8];
  assign dout.singular  = sing_o[0];
  assign dout.saturated = |sat;

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.singular |-> !dout.saturated && dout.out_c0_r0 == '0
      && dout.out_c1_r1 == '0 && dout.out_c2_r2 == '0)
    else $error("singular result with nonzero entries");

  a_sing_lanes: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> sing_o == '0 || sing_o == '1)
    else $error("lanes disagree on singular");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !dout.valid |-> din.ready)
    else $error("input stalled with output stage empty");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !dout.valid)
    else $error("result valid right after reset");

endmodule
